FILE: sv/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg: shared types and constants for the indexed ordered list
// Sizes, operation and status codes, and the control word for the cell row.
// ----------------------------------------------------------------------------
package iol_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;

  // Fixed port field widths
  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Internal count holds 0..CAPACITY
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Compare width covers both the position field and the count
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT      = 3'd0,
    MODE_APPEND      = 3'd1,
    MODE_REMOVE      = 3'd2,
    MODE_REMOVE_BACK = 3'd3,
    MODE_READ        = 3'd4,
    MODE_WRITE       = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OOB   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Control word broadcast to every cell
  typedef struct packed {
    logic              wr_en;   // load wdata at pos
    logic              shl_up;  // cells above pos take left neighbor
    logic              shl_dn;  // cells at/above pos take right neighbor
    logic [CMP_W-1:0]  pos;
    logic [DATA_W-1:0] wdata;
  } cell_ctl_t;

endpackage

FILE: sv/iol_cell.sv
// ----------------------------------------------------------------------------
// iol_cell: one entry of the list
// Holds one word; loads, shifts from a neighbor, or holds each cycle.
// ----------------------------------------------------------------------------
module iol_cell (
  input  logic                          clk,
  input  iol_pkg::cell_ctl_t            ctl,
  input  logic [iol_pkg::CMP_W-1:0]     idx,
  input  logic [iol_pkg::DATA_W-1:0]    left_data,
  input  logic [iol_pkg::DATA_W-1:0]    right_data,
  output logic [iol_pkg::DATA_W-1:0]    data,
  output logic [iol_pkg::DATA_W-1:0]    rd_data
);

  logic [iol_pkg::DATA_W-1:0] data_r;
  logic [iol_pkg::DATA_W-1:0] data_nxt;
  logic                       hit;

  assign hit = (idx == ctl.pos);

  always_comb begin
    data_nxt = data_r;
    if (ctl.wr_en && hit) begin
      data_nxt = ctl.wdata;
    end else if (ctl.shl_up && (idx > ctl.pos)) begin
      data_nxt = left_data;
    end else if (ctl.shl_dn && (idx >= ctl.pos)) begin
      data_nxt = right_data;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = hit ? data_r : '0;

endmodule

FILE: sv/iol_chain.sv
// ----------------------------------------------------------------------------
// iol_chain: row of list cells
// Wires neighbors together and merges the cells' read outputs.
// ----------------------------------------------------------------------------
module iol_chain (
  input  logic                          clk,
  input  iol_pkg::cell_ctl_t            ctl,
  output logic [iol_pkg::DATA_W-1:0]    rd_data
);

  logic [iol_pkg::DATA_W-1:0] cell_q  [iol_pkg::CAPACITY];
  logic [iol_pkg::DATA_W-1:0] cell_rd [iol_pkg::CAPACITY];

  for (genvar i = 0; i < iol_pkg::CAPACITY; i++) begin : g_cell
    logic [iol_pkg::DATA_W-1:0] left_d;
    logic [iol_pkg::DATA_W-1:0] right_d;

    // Ends of the row see zero
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == iol_pkg::CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    iol_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (iol_pkg::CMP_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // At most one cell matches pos, so an OR merge suffices
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < iol_pkg::CAPACITY; k++) begin
      rd_data = rd_data | cell_rd[k];
    end
  end

endmodule

FILE: sv/indexed_ordered_list_top.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list_top: bounded ordered list with indexed access
// Decodes one operation per transfer and drives a row of shifting cells.
// ----------------------------------------------------------------------------
// Result: registered; appears in the cycle after the start transfer, for one cycle.
// Throughput: one operation per cycle; busy stays low, since every cell
//   shifts or holds in the same cycle the operation is taken.
// Reset: synchronous active-low rst_n clears the count and the result strobe;
//   entry contents are unknown until written. The receiver cannot stall.
module indexed_ordered_list_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [iol_pkg::MODE_W-1:0]     in_mode,
  input  logic [iol_pkg::POS_W-1:0]      in_position,
  input  logic [iol_pkg::VALUE_W-1:0]    in_value,
  output logic                           out_valid,
  output logic [iol_pkg::STATUS_W-1:0]   out_status,
  output logic [iol_pkg::VALUE_W-1:0]    out_read_value,
  output logic [iol_pkg::COUNT_W-1:0]    out_entry_count
);

  // Count register and result registers
  logic [iol_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         valid_r, valid_nxt;
  iol_pkg::status_t             status_r, status_nxt;
  logic [iol_pkg::DATA_W-1:0]   rdval_r, rdval_nxt;

  iol_pkg::cell_ctl_t           ctl;
  logic [iol_pkg::DATA_W-1:0]   chain_rd;
  logic                         accept;
  logic [iol_pkg::CMP_W-1:0]    pos_ext;
  logic [iol_pkg::CMP_W-1:0]    cnt_ext;
  logic                         rd_ok;

  // Every operation completes in the cycle it is taken
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_ext = iol_pkg::CMP_W'(in_position);
  assign cnt_ext = iol_pkg::CMP_W'(cnt_r);

  // Operation decode. Range check before full check on insert;
  // empty check before range check on remove.
  always_comb begin
    ctl.wr_en  = 1'b0;
    ctl.shl_up = 1'b0;
    ctl.shl_dn = 1'b0;
    ctl.pos    = pos_ext;
    ctl.wdata  = iol_pkg::DATA_W'(in_value);
    cnt_nxt    = cnt_r;
    status_nxt = iol_pkg::ST_OK;
    rd_ok      = 1'b0;
    valid_nxt  = accept;

    if (accept) begin
      unique case (in_mode)
        iol_pkg::MODE_INSERT, iol_pkg::MODE_APPEND: begin
          if (in_mode == iol_pkg::MODE_APPEND) begin
            ctl.pos = cnt_ext;
          end
          if (ctl.pos > cnt_ext) begin
            status_nxt = iol_pkg::ST_OOB;
          end else if (cnt_r >= iol_pkg::CNT_W'(iol_pkg::CAPACITY)) begin
            status_nxt = iol_pkg::ST_FULL;
          end else begin
            ctl.wr_en  = 1'b1;
            ctl.shl_up = 1'b1;
            cnt_nxt    = cnt_r + 1'b1;
          end
        end
        iol_pkg::MODE_REMOVE: begin
          if (cnt_r == '0) begin
            status_nxt = iol_pkg::ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            status_nxt = iol_pkg::ST_OOB;
          end else begin
            ctl.shl_dn = 1'b1;
            cnt_nxt    = cnt_r - 1'b1;
          end
        end
        iol_pkg::MODE_REMOVE_BACK: begin
          // Back entry just drops out of range; no shift needed
          if (cnt_r == '0) begin
            status_nxt = iol_pkg::ST_EMPTY;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        iol_pkg::MODE_READ: begin
          if (pos_ext >= cnt_ext) begin
            status_nxt = iol_pkg::ST_OOB;
          end else begin
            rd_ok = 1'b1;
          end
        end
        iol_pkg::MODE_WRITE: begin
          if (pos_ext >= cnt_ext) begin
            status_nxt = iol_pkg::ST_OOB;
          end else begin
            ctl.wr_en = 1'b1;
          end
        end
        default: begin
          // Unused codes: no change, status ok
        end
      endcase
    end

    rdval_nxt = rd_ok ? chain_rd : '0;
  end

  iol_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (chain_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rdval_r  <= rdval_nxt;
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_read_value  = iol_pkg::VALUE_W'(rdval_r);
  assign out_entry_count = iol_pkg::COUNT_W'(cnt_r);

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= iol_pkg::CNT_W'(iol_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_valid_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result strobe missing after transfer");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == iol_pkg::ST_FULL) |->
      (cnt_r == iol_pkg::CNT_W'(iol_pkg::CAPACITY)))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == iol_pkg::ST_EMPTY) |-> (cnt_r == '0))
    else $error("empty status with entries held");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> (cnt_r == $past(cnt_r)))
    else $error("count changed without a transfer");
`endif

endmodule
